// ===== design/relaxed_jacobi_seidel_solver_assert.svh =====
// Assertion macros for the relaxed Jacobi / Gauss-Seidel solver checker.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef RELAXED_JACOBI_SEIDEL_SOLVER_ASSERT_SVH
`define RELAXED_JACOBI_SEIDEL_SOLVER_ASSERT_SVH

// same-cycle implication
`define RJS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RJS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rjs_pkg.sv =====
// Shared types, codes and saturating helpers for the diagonal-storage SOR solver.
// No dependencies; used by the solver top level and its checker.
package rjs_pkg;

    localparam int DW = 32;
    localparam int QW = 49;     // divider dividend / quotient width

    typedef logic signed [DW-1:0] data_t;
    typedef logic signed [65:0]   wide_t;
    typedef logic [2:0]           req_t;
    typedef logic [1:0]           status_t;
    typedef logic [2:0]           cfg_idx_t;

    localparam req_t REQ_OFFSET = 3'd0;
    localparam req_t REQ_MATRIX = 3'd1;
    localparam req_t REQ_RHS    = 3'd2;
    localparam req_t REQ_START  = 3'd3;
    localparam req_t REQ_SOLVE  = 3'd4;
    localparam req_t REQ_READ   = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_LIMIT = 2'd1;
    localparam status_t ST_ERROR = 2'd2;

    localparam cfg_idx_t CFG_METHOD = 3'd0;
    localparam cfg_idx_t CFG_DIM    = 3'd1;
    localparam cfg_idx_t CFG_DIAGS  = 3'd2;
    localparam cfg_idx_t CFG_RELAX  = 3'd3;
    localparam cfg_idx_t CFG_TOL    = 3'd4;
    localparam cfg_idx_t CFG_LIMIT  = 3'd5;

    localparam data_t DMAX = 32'sh7FFF_FFFF;
    localparam data_t DMIN = 32'sh8000_0000;

    function automatic data_t sat_q(input wide_t v);
        if (v > 66'(DMAX))
            return DMAX;
        if (v < 66'(DMIN))
            return DMIN;
        return data_t'(v[DW-1:0]);
    endfunction

    function automatic logic [DW-1:0] mag32(input data_t v);
        logic signed [DW:0] e;
        e = 33'(v);
        if (e < 0)
            e = -e;
        return e[DW-1:0];
    endfunction

endpackage

// ===== design/relaxed_jacobi_seidel_solver.sv =====
// Relaxed Jacobi / Gauss-Seidel solver over diagonal storage: one shared multiplier
// and one radix-2 divider under a sequencer. Depends on rjs_pkg.
// Loads answer the cycle after the request and the next may follow at once; a read
// answers from S_RD_OUT. Solve: pivot scan; Jacobi sweep of row sums, then updates
// (49-step divide); Gauss-Seidel sweep of sum and update per row; residual pass; ratio
// divide at the end. Done strobes once, no stall. Reset restores config defaults.
module relaxed_jacobi_seidel_solver #(
    parameter int MAX_DIM   = 1024,
    parameter int MAX_DIAGS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rjs_pkg::req_t      req_type,
    input  logic [2:0]         slot,
    input  logic signed [10:0] offset,
    input  logic [9:0]         index,
    input  rjs_pkg::data_t     value,
    input  logic               cfg_we,
    input  rjs_pkg::cfg_idx_t  cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output rjs_pkg::data_t     solution_value,
    output logic [9:0]         element_index,
    output logic [15:0]        iterations_done,
    output logic [31:0]        residual_ratio,
    output rjs_pkg::status_t   status
);
    import rjs_pkg::*;

    localparam int AW      = $clog2(MAX_DIM);
    localparam int NW      = $clog2(MAX_DIM + 1);
    localparam int DEPTH_D = MAX_DIAGS * MAX_DIM;
    localparam int DAW     = (DEPTH_D > 2) ? $clog2(DEPTH_D) : 1;
    localparam int SW      = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1;
    localparam int SCW     = $clog2(MAX_DIAGS + 1);
    localparam int JW      = (NW + 2 > 12) ? NW + 2 : 12;
    localparam int STW     = $clog2(QW);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RD_OUT   = 5'd1;
    localparam logic [4:0] S_PV_RD    = 5'd2;
    localparam logic [4:0] S_PV_CHK   = 5'd3;
    localparam logic [4:0] S_PV_TOL   = 5'd4;
    localparam logic [4:0] S_PV_BR    = 5'd5;
    localparam logic [4:0] S_ROW      = 5'd6;
    localparam logic [4:0] S_SLOT     = 5'd7;
    localparam logic [4:0] S_MUL      = 5'd8;
    localparam logic [4:0] S_ACC      = 5'd9;
    localparam logic [4:0] S_ROW_END  = 5'd10;
    localparam logic [4:0] S_RLX_RD   = 5'd11;
    localparam logic [4:0] S_RLX_DIFF = 5'd12;
    localparam logic [4:0] S_RLX_MUL  = 5'd13;
    localparam logic [4:0] S_RLX_DIV0 = 5'd14;
    localparam logic [4:0] S_DIV      = 5'd15;
    localparam logic [4:0] S_RLX_WB   = 5'd16;
    localparam logic [4:0] S_NEXT     = 5'd17;
    localparam logic [4:0] S_RES_CHK  = 5'd18;
    localparam logic [4:0] S_FIN      = 5'd19;
    localparam logic [4:0] S_FIN_WB   = 5'd20;

    // pass being run over the rows
    localparam logic [1:0] P_JA  = 2'd0;   // Jacobi row sums into partial store
    localparam logic [1:0] P_JB  = 2'd1;   // Jacobi updates
    localparam logic [1:0] P_GS  = 2'd2;   // Gauss-Seidel sum and update
    localparam logic [1:0] P_RES = 2'd3;   // residual norm

    // configuration
    logic               method_reg;
    logic [10:0]        dim_reg;
    logic [3:0]         diag_cnt_reg;
    logic [17:0]        relax_reg;
    logic [31:0]        tol_reg;
    logic [15:0]        limit_reg;
    logic signed [10:0] offset_tab_reg [MAX_DIAGS];

    // sequencer
    logic [4:0]         state_reg;
    logic [1:0]         mode_reg;
    logic [AW-1:0]      row_reg;
    logic [SCW-1:0]     slot_reg;
    logic               half_reg;
    data_t              acc_reg;
    logic [31:0]        yn_reg;
    logic [31:0]        rn_reg;
    logic [63:0]        tolyn_reg;
    logic [15:0]        k_reg;
    logic               conv_reg;
    data_t              diff_reg;
    data_t              aii_reg;
    data_t              xi_reg;
    wide_t              prod_reg;
    logic [QW-1:0]      dq_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic [STW-1:0]     dstep_reg;
    logic               neg_reg;
    logic [15:0]        iter_cnt_reg;
    logic [31:0]        last_res_reg;
    logic               done_reg;
    data_t              sol_out_reg;
    logic [9:0]         eidx_reg;
    status_t            status_reg;

    // stores
    data_t diag_mem [DEPTH_D];
    data_t rhs_mem  [MAX_DIM];
    data_t sol_mem  [MAX_DIM];
    data_t psum_mem [MAX_DIM];
    data_t diag_q, rhs_q, sol_q, psum_q;

    logic           diag_we, diag_re, rhs_we, rhs_re, sol_we, sol_re, psum_we, psum_re;
    logic [DAW-1:0] diag_wa, diag_ra;
    logic [AW-1:0]  rhs_wa, sol_wa, sol_ra;
    data_t          sol_wd;

    // combinational helpers
    logic [NW-1:0]      neff;
    logic [SCW-1:0]     dceff;
    logic               accept, idx_ok, dslot_ok;
    logic signed [10:0] off_cur;
    logic               slot_end, col_ok, sel_ok, last_row, conv, div_ge;
    logic signed [JW-1:0] j_s, row_s;
    logic [AW-1:0]      col_idx, pos;
    logic [DAW-1:0]     slot_addr, load_addr;
    data_t              qprod, acc_sum, res_r, diff_c, s_val, delta, x_new;
    logic [31:0]        res_mag;
    logic [65:0]        num_mag;
    logic signed [QW:0] q_signed;
    logic [32:0]        div_trial;
    logic signed [32:0] mul_a, mul_b;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        if (dim_reg == 11'd0)
            neff = NW'(1);
        else if (32'(dim_reg) > 32'(MAX_DIM))
            neff = NW'(MAX_DIM);
        else
            neff = NW'(dim_reg);
        if (diag_cnt_reg == 4'd0)
            dceff = SCW'(1);
        else if (32'(diag_cnt_reg) > 32'(MAX_DIAGS))
            dceff = SCW'(MAX_DIAGS);
        else
            dceff = SCW'(diag_cnt_reg);
    end

    assign idx_ok    = 32'(index) < 32'(neff);
    assign dslot_ok  = 32'(slot) < 32'(dceff);
    assign load_addr = DAW'(slot) * DAW'(MAX_DIM) + DAW'(index);

    // slot walk: column reached by the current diagonal from the current row
    assign off_cur   = offset_tab_reg[slot_reg[SW-1:0]];
    assign slot_end  = 32'(slot_reg) >= 32'(dceff);
    assign row_s     = JW'(signed'({1'b0, row_reg}));
    assign j_s       = row_s + JW'(off_cur);
    assign col_ok    = !j_s[JW-1] && (j_s < JW'(signed'({1'b0, neff})));
    assign sel_ok    = (mode_reg != P_GS) || (half_reg ? off_cur[10] : !off_cur[10]);
    assign col_idx   = j_s[AW-1:0];
    assign pos       = (j_s < row_s) ? j_s[AW-1:0] : row_reg;
    assign slot_addr = DAW'(slot_reg[SW-1:0]) * DAW'(MAX_DIM) + DAW'(pos);
    assign last_row  = (32'(row_reg) + 32'd1) == 32'(neff);

    // arithmetic around the shared multiplier and divider
    assign qprod    = sat_q(prod_reg >>> 16);
    assign acc_sum  = sat_q(66'(acc_reg) + 66'(qprod));
    assign res_r    = sat_q(66'(rhs_q) - 66'(acc_reg));
    assign res_mag  = mag32(res_r);
    assign s_val    = (mode_reg == P_JB) ? psum_q : acc_reg;
    assign diff_c   = sat_q(66'(rhs_q) - 66'(s_val));
    assign num_mag  = prod_reg[65] ? 66'(-prod_reg) : 66'(prod_reg);
    assign q_signed = neg_reg ? -signed'({1'b0, dq_reg}) : signed'({1'b0, dq_reg});
    assign delta    = sat_q(66'(q_signed));
    assign x_new    = sat_q(66'(xi_reg) + 66'(delta));
    assign conv     = {rn_reg, 32'h0} <= tolyn_reg;
    assign div_trial = {rem_reg[31:0], dq_reg[QW-1]};
    assign div_ge    = div_trial >= {1'b0, den_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL:
            begin
                mul_a = 33'(diag_q);
                mul_b = 33'(sol_q);
            end
            S_RLX_MUL:
            begin
                mul_a = 33'(relax_reg);
                mul_b = 33'(diff_reg);
            end
            S_PV_TOL:
            begin
                mul_a = {1'b0, tol_reg};
                mul_b = {1'b0, yn_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        diag_we = 1'b0;
        diag_re = 1'b0;
        rhs_we  = 1'b0;
        rhs_re  = 1'b0;
        sol_we  = 1'b0;
        sol_re  = 1'b0;
        psum_we = 1'b0;
        psum_re = 1'b0;
        diag_wa = load_addr;
        diag_ra = slot_addr;
        rhs_wa  = AW'(index);
        sol_wa  = row_reg;
        sol_wd  = x_new;
        sol_ra  = col_idx;
        unique case (state_reg)
            S_IDLE:
            begin
                sol_wa = AW'(index);
                sol_wd = value;
                sol_ra = AW'(index);
                if (accept)
                begin
                    case (req_type)
                        REQ_MATRIX: diag_we = dslot_ok && idx_ok;
                        REQ_RHS:    rhs_we  = idx_ok;
                        REQ_START:  sol_we  = idx_ok;
                        REQ_READ:   sol_re  = idx_ok;
                        default:    diag_we = 1'b0;
                    endcase
                end
            end
            S_PV_RD:
            begin
                diag_re = 1'b1;
                diag_ra = DAW'(row_reg);
                rhs_re  = 1'b1;
            end
            S_ROW:
                rhs_re = (mode_reg != P_JB);
            S_SLOT:
            begin
                diag_re = !slot_end && sel_ok && col_ok;
                sol_re  = !slot_end && sel_ok && col_ok;
            end
            S_ROW_END:
                psum_we = (mode_reg == P_JA);
            S_RLX_RD:
            begin
                diag_re = 1'b1;
                diag_ra = DAW'(row_reg);
                sol_re  = 1'b1;
                sol_ra  = row_reg;
                rhs_re  = 1'b1;
                psum_re = 1'b1;
            end
            S_RLX_WB:
                sol_we = 1'b1;
            default:
                diag_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (diag_we)
            diag_mem[diag_wa] <= value;
        if (diag_re)
            diag_q <= diag_mem[diag_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we)
            rhs_mem[rhs_wa] <= value;
        if (rhs_re)
            rhs_q <= rhs_mem[row_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sol_we)
            sol_mem[sol_wa] <= sol_wd;
        if (sol_re)
            sol_q <= sol_mem[sol_ra];
    end

    always_ff @(posedge clk)
    begin
        if (psum_we)
            psum_mem[row_reg] <= acc_reg;
        if (psum_re)
            psum_q <= psum_mem[row_reg];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg   <= 1'b0;
            dim_reg      <= 11'd1;
            diag_cnt_reg <= 4'd1;
            relax_reg    <= 18'd65536;
            tol_reg      <= 32'd42950;
            limit_reg    <= 16'd100;
            for (int s = 0; s < MAX_DIAGS; s++)
                offset_tab_reg[s] <= '0;
            state_reg    <= S_IDLE;
            mode_reg     <= P_JA;
            row_reg      <= '0;
            slot_reg     <= '0;
            half_reg     <= 1'b0;
            acc_reg      <= '0;
            yn_reg       <= '0;
            rn_reg       <= '0;
            tolyn_reg    <= '0;
            k_reg        <= '0;
            conv_reg     <= 1'b0;
            diff_reg     <= '0;
            aii_reg      <= '0;
            xi_reg       <= '0;
            dq_reg       <= '0;
            rem_reg      <= '0;
            den_reg      <= '0;
            dstep_reg    <= '0;
            neg_reg      <= 1'b0;
            iter_cnt_reg <= '0;
            last_res_reg <= '0;
            done_reg     <= 1'b0;
            sol_out_reg  <= '0;
            eidx_reg     <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_METHOD: method_reg   <= cfg_data[0];
                    CFG_DIM:    dim_reg      <= cfg_data[10:0];
                    CFG_DIAGS:  diag_cnt_reg <= cfg_data[3:0];
                    CFG_RELAX:  relax_reg    <= cfg_data[17:0];
                    CFG_TOL:    tol_reg      <= cfg_data;
                    CFG_LIMIT:  limit_reg    <= cfg_data[15:0];
                    default:    method_reg   <= method_reg;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sol_out_reg <= '0;
                        eidx_reg    <= index;
                        status_reg  <= ST_OK;
                        done_reg    <= 1'b1;
                        case (req_type)
                            REQ_OFFSET:
                            begin
                                if (32'(slot) >= 32'(MAX_DIAGS) || (slot == 3'd0 && offset != 11'sd0))
                                    status_reg <= ST_ERROR;
                                else
                                    offset_tab_reg[SW'(slot)] <= offset;
                            end
                            REQ_MATRIX:
                                if (!(dslot_ok && idx_ok))
                                    status_reg <= ST_ERROR;
                            REQ_RHS, REQ_START:
                                if (!idx_ok)
                                    status_reg <= ST_ERROR;
                            REQ_SOLVE:
                            begin
                                done_reg  <= 1'b0;
                                eidx_reg  <= '0;
                                row_reg   <= '0;
                                yn_reg    <= '0;
                                state_reg <= S_PV_RD;
                            end
                            REQ_READ:
                            begin
                                if (idx_ok)
                                begin
                                    done_reg  <= 1'b0;
                                    state_reg <= S_RD_OUT;
                                end
                                else
                                    status_reg <= ST_ERROR;
                            end
                            default:
                                status_reg <= ST_ERROR;
                        endcase
                    end
                end
                S_RD_OUT:
                begin
                    sol_out_reg <= sol_q;
                    done_reg    <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                S_PV_RD:
                    state_reg <= S_PV_CHK;
                S_PV_CHK:
                begin
                    if (diag_q == '0)
                    begin
                        // zero pivot: nothing solved
                        iter_cnt_reg <= '0;
                        last_res_reg <= '1;
                        status_reg   <= ST_ERROR;
                        done_reg     <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        if (mag32(rhs_q) > yn_reg)
                            yn_reg <= mag32(rhs_q);
                        if (last_row)
                            state_reg <= S_PV_TOL;
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= S_PV_RD;
                        end
                    end
                end
                S_PV_TOL:
                    state_reg <= S_PV_BR;
                S_PV_BR:
                begin
                    tolyn_reg <= prod_reg[63:0];
                    k_reg     <= '0;
                    row_reg   <= '0;
                    rn_reg    <= '0;
                    if (limit_reg == 16'd0)
                        mode_reg <= P_RES;
                    else
                        mode_reg <= method_reg ? P_GS : P_JA;
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    acc_reg  <= '0;
                    slot_reg <= '0;
                    half_reg <= 1'b0;
                    state_reg <= (mode_reg == P_JB) ? S_RLX_RD : S_SLOT;
                end
                S_SLOT:
                begin
                    if (slot_end)
                    begin
                        // Gauss-Seidel walks the slots twice: upper then lower diagonals
                        if (mode_reg == P_GS && !half_reg)
                        begin
                            half_reg <= 1'b1;
                            slot_reg <= '0;
                        end
                        else
                            state_reg <= S_ROW_END;
                    end
                    else if (sel_ok && col_ok)
                        state_reg <= S_MUL;
                    else
                        slot_reg <= slot_reg + 1'b1;
                end
                S_MUL:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    acc_reg   <= acc_sum;
                    slot_reg  <= slot_reg + 1'b1;
                    state_reg <= S_SLOT;
                end
                S_ROW_END:
                begin
                    if (mode_reg == P_GS)
                        state_reg <= S_RLX_RD;
                    else
                    begin
                        if (mode_reg == P_RES && res_mag > rn_reg)
                            rn_reg <= res_mag;
                        state_reg <= S_NEXT;
                    end
                end
                S_RLX_RD:
                    state_reg <= S_RLX_DIFF;
                S_RLX_DIFF:
                begin
                    diff_reg  <= diff_c;
                    aii_reg   <= diag_q;
                    xi_reg    <= sol_q;
                    state_reg <= S_RLX_MUL;
                end
                S_RLX_MUL:
                    state_reg <= S_RLX_DIV0;
                S_RLX_DIV0:
                begin
                    dq_reg    <= num_mag[QW-1:0];
                    rem_reg   <= '0;
                    den_reg   <= mag32(aii_reg);
                    neg_reg   <= prod_reg[65] ^ aii_reg[31];
                    dstep_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg   <= div_ge ? div_trial - {1'b0, den_reg} : div_trial;
                    dq_reg    <= {dq_reg[QW-2:0], div_ge};
                    dstep_reg <= dstep_reg + 1'b1;
                    if (32'(dstep_reg) == QW - 1)
                        state_reg <= (mode_reg == P_RES) ? S_FIN_WB : S_RLX_WB;
                end
                S_RLX_WB:
                    state_reg <= S_NEXT;
                S_NEXT:
                begin
                    if (last_row)
                    begin
                        row_reg <= '0;
                        case (mode_reg)
                            P_JA:
                            begin
                                mode_reg  <= P_JB;
                                state_reg <= S_ROW;
                            end
                            P_RES:
                                state_reg <= S_RES_CHK;
                            default:
                            begin
                                k_reg     <= k_reg + 1'b1;
                                rn_reg    <= '0;
                                mode_reg  <= P_RES;
                                state_reg <= S_ROW;
                            end
                        endcase
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= S_ROW;
                    end
                end
                S_RES_CHK:
                begin
                    conv_reg <= conv;
                    if (conv || k_reg >= limit_reg)
                        state_reg <= S_FIN;
                    else
                    begin
                        mode_reg  <= method_reg ? P_GS : P_JA;
                        row_reg   <= '0;
                        state_reg <= S_ROW;
                    end
                end
                S_FIN:
                begin
                    if (yn_reg == '0)
                    begin
                        last_res_reg <= (rn_reg != '0) ? '1 : '0;
                        iter_cnt_reg <= k_reg;
                        status_reg   <= conv_reg ? ST_OK : ST_LIMIT;
                        done_reg     <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        // ratio = (rn << 16) / yn through the shared divider
                        dq_reg    <= {1'b0, rn_reg, 16'h0};
                        rem_reg   <= '0;
                        den_reg   <= yn_reg;
                        neg_reg   <= 1'b0;
                        dstep_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_FIN_WB:
                begin
                    last_res_reg <= (|dq_reg[QW-1:32]) ? '1 : dq_reg[31:0];
                    iter_cnt_reg <= k_reg;
                    status_reg   <= conv_reg ? ST_OK : ST_LIMIT;
                    done_reg     <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done            = done_reg;
    assign solution_value  = sol_out_reg;
    assign element_index   = eidx_reg;
    assign iterations_done = iter_cnt_reg;
    assign residual_ratio  = last_res_reg;
    assign status          = status_reg;

endmodule

// ===== design/rjs_checker.sv =====
// Port-level checker for the SOR solver, bound to the top level.
// Depends on rjs_pkg and relaxed_jacobi_seidel_solver_assert.svh.
`include "relaxed_jacobi_seidel_solver_assert.svh"

module rjs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input rjs_pkg::req_t      req_type,
    input logic               done,
    input rjs_pkg::data_t     solution_value,
    input logic [9:0]         element_index,
    input rjs_pkg::status_t   status
);
    import rjs_pkg::*;

    // load requests answer on the next cycle
    `RJS_ASSERT_NXT(a_load_next, start && !busy && req_type != REQ_SOLVE && req_type != REQ_READ, done, "load request not answered next cycle")
    `RJS_ASSERT_NXT(a_solve_busy, start && !busy && req_type == REQ_SOLVE, busy, "solve request did not hold busy")
    `RJS_ASSERT_IMP(a_done_idle, done, !busy, "result strobed while busy")
    `RJS_ASSERT_IMP(a_err_zero, done && status == ST_ERROR, solution_value == 0, "error result carries data")
    // only a solve reports the limit status, and a solve has index zero
    `RJS_ASSERT_IMP(a_limit_idx, done && status == ST_LIMIT, element_index == 0, "limit status with nonzero index")

endmodule

bind relaxed_jacobi_seidel_solver rjs_checker u_rjs_checker (.*);
